/* rtl/interpolating_sample_rate_converter_unit_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef INTERPOLATING_SAMPLE_RATE_CONVERTER_UNIT_ASSERT_SVH
`define INTERPOLATING_SAMPLE_RATE_CONVERTER_UNIT_ASSERT_SVH

// Property checked while the block is out of reset.
`define ISRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ISRC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/isrc_pkg.sv */
`default_nettype none
package isrc_pkg;

  localparam int SINC_TAPS   = 8;
  localparam int PHASE_BITS  = 6;
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_RESULTS = 64;

  localparam int FRAC_BITS  = 16;
  localparam int ONE_Q16    = 65536;
  localparam int POS_BITS   = 24;
  localparam int IDX_BITS   = 5;
  localparam int STEP_BITS  = 21;
  localparam int STEP_MIN   = 4096;
  localparam int STEP_MAX   = 1048576;
  localparam int WEIGHT_BITS = 18;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PASS   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO = 3'd3;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_CUBIC  = 2'd1;
  localparam logic [1:0] MODE_SINC   = 2'd2;

  // One output position handed to both lanes.
  typedef struct packed {
    logic                 start;
    logic [1:0]           mode;
    logic [IDX_BITS-1:0]  slot;
    logic [IDX_BITS-1:0]  lo;
    logic [FRAC_BITS-1:0] frac;
  } lane_cmd_t;

  // Load request for the output register.
  typedef struct packed {
    logic load;
    logic pass;
    logic run_end;
    logic stream_done;
  } out_ctl_t;

endpackage
`default_nettype wire

/* rtl/isrc_lane.sv */
`default_nettype none
module isrc_lane #(
  parameter int SINC_TAPS   = isrc_pkg::SINC_TAPS,
  parameter int PHASE_BITS  = isrc_pkg::PHASE_BITS,
  parameter int SAMPLE_BITS = isrc_pkg::SAMPLE_BITS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           push,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire isrc_pkg::lane_cmd_t      cmd,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int SW     = $clog2(SINC_TAPS);
  localparam int HALF   = SINC_TAPS / 2;
  localparam int PHASES = 1 << PHASE_BITS;
  localparam int WW     = isrc_pkg::WEIGHT_BITS;
  localparam int AW     = SAMPLE_BITS + 7;
  localparam int PW     = AW + WW;
  localparam int IW     = SW + 3;
  localparam int TW     = $clog2(PHASES * SINC_TAPS);
  localparam int FB     = isrc_pkg::FRAC_BITS;

  localparam logic signed [IW-1:0] LAST_IDX = IW'(SINC_TAPS - 1);
  localparam logic signed [IW-1:0] OFF_SINC = IW'(-HALF);
  localparam logic signed [IW-1:0] OFF_LOAD = IW'(-1);
  localparam logic signed [WW-1:0] ONE_W    = WW'(isrc_pkg::ONE_Q16);
  localparam logic signed [PW-1:0] HALF16   = PW'(32768);
  localparam logic signed [PW-1:0] SMAX =
    $signed({{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [PW-1:0] SMIN =
    $signed({{(PW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

  // Sinc weights in Q16, one row per phase, built at elaboration by integer code.
  function automatic logic [PHASES*SINC_TAPS*WW-1:0] build_weights();
    logic [PHASES*SINC_TAPS*WW-1:0] tab;
    logic [63:0] u, u2, term, num, den, mag, n, r, s, ad;
    logic signed [63:0] sum, d;
    logic [64:0] rem;
    logic [WW-1:0] w;
    logic neg;
    int ph, t, i, k;
    tab = '0;
    for (ph = 0; ph < PHASES; ph++) begin
      s = 64'd0;
      if (ph != 0) begin
        r = (ph <= PHASES / 2) ? 64'(ph) : 64'(PHASES - ph);
        u = (64'd3373259426 * r) >> PHASE_BITS;
        u2 = (u * u) >> 30;
        term = u;
        sum = $signed(u);
        term = ((term * u2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * u2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * u2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * u2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * u2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * u2) >> 30) / 64'd156; sum = sum + $signed(term);
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        s = 64'(sum);
      end
      for (t = 0; t < SINC_TAPS; t++) begin
        i = t - HALF;
        if (ph == 0) begin
          w = (i == 0) ? WW'(isrc_pkg::ONE_Q16) : '0;
        end else begin
          d = 64'(i * PHASES - ph);
          ad = (d < 0) ? 64'(-d) : 64'(d);
          num = s << (PHASE_BITS + 16);
          den = 64'd3373259426 * ad;
          n = num + (den >> 1);
          rem = '0;
          mag = '0;
          for (k = 63; k >= 0; k--) begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, den}) begin
              rem = rem - {1'b0, den};
              mag[k] = 1'b1;
            end
          end
          neg = (i[0] == 1'b0) != (d < 0);
          w = neg ? WW'(-mag[WW-1:0]) : mag[WW-1:0];
        end
        tab[(ph * SINC_TAPS + t) * WW +: WW] = w;
      end
    end
    return tab;
  endfunction

  localparam logic [PHASES*SINC_TAPS*WW-1:0] WTAB = build_weights();

  function automatic logic signed [IW-1:0] clamp_idx(input logic signed [IW-1:0] s,
                                                    input logic signed [IW-1:0] lo);
    if (s < lo) return lo;
    if (s > LAST_IDX) return LAST_IDX;
    return s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW-1:0] v);
    if (v > SMAX) return SMAX[SAMPLE_BITS-1:0];
    if (v < SMIN) return SMIN[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_LOAD = 5'b00010,
    L_MUL  = 5'b00100,
    L_ACC  = 5'b01000,
    L_FIN  = 5'b10000
  } lstate_t;

  lstate_t state;
  logic signed [SAMPLE_BITS-1:0] hist [SINC_TAPS];
  logic signed [SAMPLE_BITS-1:0] p [4];
  logic [1:0]             mode_q;
  logic signed [IW-1:0]   slot_q, lo_q;
  logic [FB-1:0]          frac_q;
  logic [SW-1:0]          cnt;
  logic signed [AW-1:0]   t_acc;
  logic signed [PW-1:0]   acc, preg;

  logic is_cub, is_sinc, in_rng, last_mac;
  logic signed [IW-1:0] off, rd_raw, rd_cl, rd_idx;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [AW-1:0] e0, e1, e2, e3, a0, a1, a2, a3, a_next, op_a, r16;
  logic signed [WW-1:0] op_b, wsel;
  logic signed [PW-1:0] mul, r16_full, fin_val;
  logic [TW-1:0] widx;
  logic [1:0] cmd_mode;

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < SINC_TAPS - 1; i++) hist[i] <= hist[i+1];
      hist[SINC_TAPS-1] <= sample_in;
    end
  end

  assign is_cub  = (mode_q == isrc_pkg::MODE_CUBIC);
  assign is_sinc = (mode_q == isrc_pkg::MODE_SINC);

  always_comb begin
    if (state == L_LOAD) off = OFF_LOAD;
    else if (is_sinc) off = OFF_SINC;
    else off = '0;
    rd_raw = slot_q + IW'($signed({1'b0, cnt})) + off;
    rd_cl = clamp_idx(rd_raw, lo_q);
    in_rng = (rd_raw >= lo_q) && (rd_raw <= LAST_IDX);
    rd_idx = is_sinc ? (in_rng ? rd_raw : lo_q) : rd_cl;
  end

  assign rd_data = hist[rd_idx[SW-1:0]];

  assign e0 = AW'(p[0]);
  assign e1 = AW'(p[1]);
  assign e2 = AW'(p[2]);
  assign e3 = AW'(p[3]);
  assign a0 = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
  assign a1 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign a2 = e2 - e0;
  assign a3 = e1 <<< 1;

  always_comb begin
    if (cnt == SW'(0)) a_next = a1;
    else if (cnt == SW'(1)) a_next = a2;
    else a_next = a3;
  end

  assign widx = TW'(frac_q[FB-1 -: PHASE_BITS] * SINC_TAPS + cnt);
  assign wsel = WTAB[widx * WW +: WW];

  always_comb begin
    if (is_cub) begin
      op_a = (cnt == SW'(0)) ? a0 : t_acc;
      op_b = $signed({2'b00, frac_q});
    end else if (is_sinc) begin
      op_a = in_rng ? AW'(rd_data) : '0;
      op_b = wsel;
    end else begin
      op_a = AW'(rd_data);
      op_b = (cnt == SW'(0)) ? ONE_W - $signed({2'b00, frac_q}) : $signed({2'b00, frac_q});
    end
  end

  assign mul = op_a * op_b;
  assign r16_full = (preg + HALF16) >>> 16;
  assign r16 = r16_full[AW-1:0];
  assign last_mac = is_sinc ? (cnt == SW'(SINC_TAPS - 1)) : (cnt == SW'(1));
  assign fin_val = is_cub ? (PW'(t_acc) + PW'(1)) >>> 1 : (acc + HALF16) >>> 16;
  assign cmd_mode = cmd.mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            mode_q <= cmd_mode;
            slot_q <= IW'($signed({1'b0, cmd.slot}));
            lo_q <= IW'($signed({1'b0, cmd.lo}));
            frac_q <= cmd.frac;
            cnt <= '0;
            if (cmd_mode == isrc_pkg::MODE_CUBIC) begin
              state <= L_LOAD;
            end else if (cmd_mode == isrc_pkg::MODE_SINC) begin
              state <= L_MUL;
            end else if (cmd.slot == isrc_pkg::IDX_BITS'(SINC_TAPS - 1)) begin
              // At the newest frame linear mode returns that frame unchanged.
              result <= hist[SINC_TAPS-1];
              done <= 1'b1;
            end else begin
              state <= L_MUL;
            end
          end
        end
        L_LOAD: begin
          p[cnt[1:0]] <= rd_data;
          if (cnt == SW'(3)) begin
            cnt <= '0;
            state <= L_MUL;
          end else begin
            cnt <= cnt + SW'(1);
          end
        end
        L_MUL: begin
          preg <= mul;
          state <= L_ACC;
        end
        L_ACC: begin
          if (is_cub) begin
            t_acc <= r16 + a_next;
            if (cnt == SW'(2)) state <= L_FIN;
            else begin
              cnt <= cnt + SW'(1);
              state <= L_MUL;
            end
          end else begin
            acc <= ((cnt == SW'(0)) ? '0 : acc) + preg;
            if (last_mac) state <= L_FIN;
            else begin
              cnt <= cnt + SW'(1);
              state <= L_MUL;
            end
          end
        end
        L_FIN: begin
          result <= sat(fin_val);
          done <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/isrc_merge.sv */
`default_nettype none
module isrc_merge #(
  parameter int SAMPLE_BITS = isrc_pkg::SAMPLE_BITS,
  parameter int DATA_W      = 48
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire isrc_pkg::out_ctl_t         ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] lane_left,
  input  wire logic signed [SAMPLE_BITS-1:0] lane_right,
  input  wire logic signed [SAMPLE_BITS-1:0] pass_left,
  input  wire logic signed [SAMPLE_BITS-1:0] pass_right,
  input  wire                             m_tready,
  output logic                            m_tvalid,
  output logic [DATA_W-1:0]               m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.pass) begin
        m_tdata <= DATA_W'({pass_right, pass_left});
      end else begin
        m_tdata <= DATA_W'({lane_right, lane_left});
      end
      m_tuser <= ctl.run_end;
      m_tlast <= ctl.stream_done;
    end
  end

endmodule
`default_nettype wire

/* rtl/interpolating_sample_rate_converter_unit.sv */
`default_nettype none
// Stereo fractional resampler. Each input item is one frame (s_tdata: left, right; s_tlast
// ends the stream and flushes the remaining output positions); each result item is one
// interpolated frame (m_tdata: left, right; m_tuser marks the last result of an input item;
// m_tlast marks the final frame of the stream). Two lanes, one per channel, each keep the
// frame history and own one multiply-accumulate unit that walks the taps of one output
// position at a time. Each output frame that an input item releases is computed by the lane
// multiply-accumulate in linear, cubic or sinc mode (in linear mode a position that sits on
// the newest frame returns that frame directly) and is loaded into the output register
// while that register is free. A finished result waits in the output register while the
// next item is taken. In pass-through mode an item yields one result.
module interpolating_sample_rate_converter_unit #(
  parameter int SINC_TAPS   = isrc_pkg::SINC_TAPS,
  parameter int PHASE_BITS  = isrc_pkg::PHASE_BITS,
  parameter int SAMPLE_BITS = isrc_pkg::SAMPLE_BITS,
  localparam int DATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire [DATA_W-1:0]                      s_tdata,   // left_in, right_in
  input  wire                                   s_tlast,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [DATA_W-1:0]                     m_tdata,   // left_out, right_out
  output logic                                  m_tuser,   // run_end
  output logic                                  m_tlast,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [isrc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire [isrc_pkg::STEP_BITS-1:0]         cfg_data
);

  localparam int SW  = $clog2(SINC_TAPS);
  localparam int PB  = isrc_pkg::POS_BITS;
  localparam int FW  = $clog2(SINC_TAPS + 1);
  localparam int RW  = $clog2(isrc_pkg::MAX_RESULTS + 1);
  localparam int XB  = isrc_pkg::IDX_BITS;
  localparam int HALF = SINC_TAPS / 2;
  localparam logic signed [PB-1:0] ONE_POS   = PB'(isrc_pkg::ONE_Q16);
  localparam logic signed [PB-1:0] SPAN_POS  = PB'(SINC_TAPS * isrc_pkg::ONE_Q16);
  localparam logic signed [PB-1:0] LIMIT_RUN = PB'((1 - HALF) * isrc_pkg::ONE_Q16);
  localparam logic [RW-1:0] MAX_RES = RW'(isrc_pkg::MAX_RESULTS);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_PASS  = 5'b00010,
    T_CHECK = 5'b00100,
    T_RUN   = 5'b01000,
    T_OUT   = 5'b10000
  } tstate_t;

  tstate_t state;
  logic [1:0]                     mode_r;
  logic [isrc_pkg::STEP_BITS-1:0] step_r;
  logic                           pass_r, stereo_r;
  logic signed [PB-1:0]           rp;
  logic [FW-1:0]                  frames;
  logic [RW-1:0]                  res_cnt;
  logic                           last_q;
  logic signed [SAMPLE_BITS-1:0]  in_l, in_r;

  logic accept, out_free, cond_now, cond_next, l_done, r_done;
  logic signed [SAMPLE_BITS-1:0] s_left, s_right, r_eff, l_res, r_res;
  logic [isrc_pkg::STEP_BITS-1:0] step_eff;
  logic signed [PB-1:0] limit, rp_adv, pos_sel, pp_raw, pp;
  isrc_pkg::lane_cmd_t cmd;
  isrc_pkg::out_ctl_t  octl;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == T_IDLE);
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign s_left  = $signed(s_tdata[SAMPLE_BITS-1:0]);
  assign s_right = $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign r_eff   = stereo_r ? s_right : s_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= isrc_pkg::MODE_LINEAR;
      step_r <= isrc_pkg::STEP_BITS'(isrc_pkg::ONE_Q16);
      pass_r <= 1'b0;
      stereo_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        isrc_pkg::REG_MODE:   mode_r <= cfg_data[1:0];
        isrc_pkg::REG_STEP:   step_r <= cfg_data;
        isrc_pkg::REG_PASS:   pass_r <= cfg_data[0];
        isrc_pkg::REG_STEREO: stereo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (step_r < isrc_pkg::STEP_BITS'(isrc_pkg::STEP_MIN))
      step_eff = isrc_pkg::STEP_BITS'(isrc_pkg::STEP_MIN);
    else if (step_r > isrc_pkg::STEP_BITS'(isrc_pkg::STEP_MAX))
      step_eff = isrc_pkg::STEP_BITS'(isrc_pkg::STEP_MAX);
    else
      step_eff = step_r;
  end

  assign limit = last_q ? '0 : LIMIT_RUN;
  assign rp_adv = rp + $signed(PB'(step_eff));
  assign cond_now = (rp < limit) && (res_cnt < MAX_RES);
  assign cond_next = (rp_adv < limit) && ((res_cnt + RW'(1)) < MAX_RES);

  // The next position comes from the advanced pointer when a result is being handed off.
  assign pos_sel = (state == T_OUT) ? rp_adv : rp;
  assign pp_raw = pos_sel + SPAN_POS;
  assign pp = (pp_raw < 0) ? '0 : pp_raw;

  always_comb begin
    cmd.start = ((state == T_CHECK) && cond_now) || ((state == T_OUT) && out_free && cond_next);
    cmd.mode = mode_r;
    cmd.slot = XB'(pp[isrc_pkg::FRAC_BITS +: SW]);
    cmd.lo = XB'(SINC_TAPS - frames);
    cmd.frac = pp[isrc_pkg::FRAC_BITS-1:0];
  end

  always_comb begin
    octl.load = out_free && ((state == T_PASS) || (state == T_OUT));
    octl.pass = (state == T_PASS);
    octl.run_end = (state == T_PASS) ? 1'b1 : !cond_next;
    octl.stream_done = (state == T_PASS) ? last_q : (last_q && !cond_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      rp <= '0;
      frames <= '0;
      res_cnt <= '0;
      last_q <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            in_l <= s_left;
            in_r <= r_eff;
            last_q <= s_tlast;
            if (pass_r) begin
              state <= T_PASS;
            end else begin
              if (frames != FW'(SINC_TAPS)) frames <= frames + FW'(1);
              rp <= rp - ONE_POS;
              res_cnt <= '0;
              state <= T_CHECK;
            end
          end
        end
        T_PASS: begin
          if (out_free) state <= T_IDLE;
        end
        T_CHECK: begin
          if (cond_now) begin
            state <= T_RUN;
          end else begin
            if (last_q) begin
              rp <= '0;
              frames <= '0;
            end
            state <= T_IDLE;
          end
        end
        T_RUN: begin
          if (l_done && r_done) state <= T_OUT;
        end
        T_OUT: begin
          if (out_free) begin
            rp <= rp_adv;
            res_cnt <= res_cnt + RW'(1);
            if (cond_next) begin
              state <= T_RUN;
            end else begin
              if (last_q) begin
                rp <= '0;
                frames <= '0;
              end
              state <= T_IDLE;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  isrc_lane #(
    .SINC_TAPS(SINC_TAPS), .PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_left (
    .clk(clk), .rst(rst), .push(accept && !pass_r), .sample_in(s_left),
    .cmd(cmd), .done(l_done), .result(l_res)
  );

  // Both lanes run in lockstep on the same command, so their done flags rise together.
  isrc_lane #(
    .SINC_TAPS(SINC_TAPS), .PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_right (
    .clk(clk), .rst(rst), .push(accept && !pass_r), .sample_in(r_eff),
    .cmd(cmd), .done(r_done), .result(r_res)
  );

  isrc_merge #(
    .SAMPLE_BITS(SAMPLE_BITS), .DATA_W(DATA_W)
  ) u_merge (
    .clk(clk), .rst(rst), .ctl(octl),
    .lane_left(l_res), .lane_right(r_res),
    .pass_left(in_l), .pass_right(in_r),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule
`default_nettype wire

/* rtl/isrc_checker.sv */
`default_nettype none
`include "interpolating_sample_rate_converter_unit_assert.svh"
module isrc_checker #(
  parameter int DATA_W = 48
) (
  input wire                                clk,
  input wire                                rst,
  input wire                                s_tvalid,
  input wire                                s_tready,
  input wire [DATA_W-1:0]                   s_tdata,
  input wire                                s_tlast,
  input wire                                m_tvalid,
  input wire                                m_tready,
  input wire [DATA_W-1:0]                   m_tdata,
  input wire                                m_tuser,
  input wire                                m_tlast,
  input wire                                cfg_valid,
  input wire                                cfg_ready,
  input wire [isrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input wire [isrc_pkg::STEP_BITS-1:0]      cfg_data
);

  `ISRC_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `ISRC_ASSERT(a_done_on_end, clk, rst, m_tvalid && m_tlast |-> m_tuser, "stream end without run end")
  `ISRC_ASSERT(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "item taken while busy")
  `ISRC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind interpolating_sample_rate_converter_unit isrc_checker #(.DATA_W(DATA_W)) u_isrc_checker (.*);
`default_nettype wire
